/* rtl/psa_pkg.sv */
// Shared constants and types for the periodic slot allocator.
package psa_pkg;

   localparam int TableEntriesDef = 16;
   localparam int SlotW = 16;

   localparam logic [SlotW-1:0] SLOT_NONE = 16'hFFFF;

   localparam logic [1:0] FUNC_CLEAR    = 2'd0;
   localparam logic [1:0] FUNC_RESERVE  = 2'd1;
   localparam logic [1:0] FUNC_ALLOCATE = 2'd2;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_NOFREE = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;

   typedef struct packed {
      logic clear;  // drop all lanes
      logic load;   // load one lane with modulus and residue
      logic init;   // set residue counters for candidate slot 1
      logic step;   // advance to next candidate
   } lane_ctl_type;

endpackage

/* rtl/psa_serial_mod.sv */
// Bit-serial restoring remainder unit, one dividend bit per cycle.
module psa_serial_mod (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [psa_pkg::SlotW-1:0] dividend,
   input  logic [psa_pkg::SlotW-1:0] divisor,
   output logic                      done,
   output logic [psa_pkg::SlotW-1:0] remainder
);
   import psa_pkg::*;

   localparam int StepW = $clog2(SlotW);

   logic [SlotW-1:0] quo_ff, quo_in;
   logic [SlotW-1:0] rem_ff, rem_in;
   logic [SlotW-1:0] dvs_ff, dvs_in;
   logic [StepW-1:0] step_ff, step_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [SlotW:0]   trial;
   logic             ge;

   always_comb begin
      trial = {rem_ff, quo_ff[SlotW-1]};
      ge = trial >= {1'b0, dvs_ff};
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so the low bits hold it
         rem_in = ge ? SlotW'(trial - {1'b0, dvs_ff}) : trial[SlotW-1:0];
         quo_in = {quo_ff[SlotW-2:0], 1'b0};
         step_in = step_ff + StepW'(1);
         if (step_ff == StepW'(SlotW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      step_ff <= step_in;
   end

   assign done = done_ff;
   assign remainder = rem_ff;

endmodule

/* rtl/psa_scan_lanes.sv */
// One residue counter lane per table entry; flags whether the current candidate is free.
module psa_scan_lanes #(
   parameter int TABLE_ENTRIES = psa_pkg::TableEntriesDef
) (
   input  logic                      clock,
   input  logic                      reset,
   input  psa_pkg::lane_ctl_type     ctl,
   input  logic [((TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1)-1:0] load_idx,
   input  logic [psa_pkg::SlotW-1:0] load_mod,
   input  logic [psa_pkg::SlotW-1:0] load_res,
   output logic                      cand_free
);
   import psa_pkg::*;

   logic             act_ff   [TABLE_ENTRIES];
   logic [SlotW-1:0] mod_ff   [TABLE_ENTRIES];
   logic [SlotW-1:0] res_ff   [TABLE_ENTRIES];
   logic [SlotW-1:0] cnt_ff   [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] hit;

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_lane
      logic             act_in;
      logic [SlotW-1:0] mod_in, res_in, cnt_in;
      logic             wrap;

      always_comb begin
         wrap = ({1'b0, cnt_ff[i]} + (SlotW+1)'(1)) == {1'b0, mod_ff[i]};
         act_in = act_ff[i];
         mod_in = mod_ff[i];
         res_in = res_ff[i];
         cnt_in = cnt_ff[i];
         if (ctl.clear) begin
            act_in = 1'b0;
         end else if (ctl.load && (load_idx == i)) begin
            act_in = 1'b1;
            mod_in = load_mod;
            res_in = load_res;
         end else if (ctl.init) begin
            cnt_in = (mod_ff[i] == SlotW'(1)) ? '0 : SlotW'(1);
         end else if (ctl.step) begin
            cnt_in = wrap ? '0 : cnt_ff[i] + SlotW'(1);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            act_ff[i] <= 1'b0;
         end else begin
            act_ff[i] <= act_in;
         end
         mod_ff[i] <= mod_in;
         res_ff[i] <= res_in;
         cnt_ff[i] <= cnt_in;
      end

      assign hit[i] = act_ff[i] && (cnt_ff[i] == res_ff[i]);
   end

   assign cand_free = ~|hit;

endmodule

/* rtl/periodic_slot_allocator.sv */
// Top level of the periodic slot allocator: control sequencer and entry table.
//
// Input item: req_tuser = operation (clear, reserve, allocate), req_tdata = period
// and slot. One result item per input item on the rsp_ channel: rsp_tuser = status,
// rsp_tdata = granted slot. One item is processed at a time; req_tready is high
// only while the sequencer is idle.
// Clear, reserve, a full table, an empty-table allocate, an allocate with a
// period of 0 or 1 and unused operations go straight to the result state. An
// allocate against a nonempty table first prepares one residue lane per stored
// entry: a table read plus up to two bit-serial remainders (none for an
// unassigned entry). It then tests one candidate slot per cycle over all lanes.
// The remainder unit takes one dividend bit per cycle.
// Reset empties the table; stored entries are not cleared. A stalled receiver
// holds the result in the output register; the next item may be taken meanwhile,
// but its result waits until the pending result has left.
module periodic_slot_allocator #(
   parameter int TABLE_ENTRIES = psa_pkg::TableEntriesDef
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] req_period, [31:16] req_slot
   input  logic [1:0]  req_tuser,   // [1:0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] granted_slot
   output logic [1:0]  rsp_tuser    // [1:0] status
);
   import psa_pkg::*;

   localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CntW = $clog2(TABLE_ENTRIES + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_RD    = 3'd1;
   localparam logic [2:0] S_CHK   = 3'd2;
   localparam logic [2:0] S_DIV1  = 3'd3;
   localparam logic [2:0] S_DIV2  = 3'd4;
   localparam logic [2:0] S_SINIT = 3'd5;
   localparam logic [2:0] S_SCAN  = 3'd6;
   localparam logic [2:0] S_FIN   = 3'd7;

   logic [SlotW-1:0] mem_per [TABLE_ENTRIES];
   logic [SlotW-1:0] mem_slot[TABLE_ENTRIES];

   logic [2:0]       state_ff, state_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic [IdxW-1:0]  idx_ff, idx_in;
   logic [SlotW-1:0] per_ff, per_in;
   logic [SlotW-1:0] cand_ff, cand_in;
   logic [SlotW-1:0] small_ff, small_in;
   logic [1:0]       st_ff, st_in;
   logic [SlotW-1:0] gs_ff, gs_in;
   logic [SlotW-1:0] rd_per_ff, rd_slot_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_st_ff, rsp_st_in;
   logic [SlotW-1:0] rsp_slot_ff, rsp_slot_in;

   logic             wr_en;
   logic [SlotW-1:0] wr_per, wr_slot;
   logic             mod_start, mod_done;
   logic [SlotW-1:0] mod_dividend, mod_divisor, mod_rem;
   lane_ctl_type     lane_ctl;
   logic             cand_free;
   logic             accept, full, last_entry;
   logic [SlotW-1:0] in_per, in_slot;

   assign in_per = req_tdata[15:0];
   assign in_slot = req_tdata[31:16];
   assign req_tready = (state_ff == S_IDLE);
   assign accept = req_tvalid && req_tready;
   assign full = (count_ff == CntW'(TABLE_ENTRIES));
   assign last_entry = ((CntW'(idx_ff) + CntW'(1)) == count_ff);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      per_in = per_ff;
      cand_in = cand_ff;
      small_in = small_ff;
      st_in = st_ff;
      gs_in = gs_ff;
      wr_en = 1'b0;
      wr_per = per_ff;
      wr_slot = cand_ff;
      mod_start = 1'b0;
      mod_dividend = rd_slot_ff;
      mod_divisor = small_ff;
      lane_ctl = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_st_in = rsp_st_ff;
      rsp_slot_in = rsp_slot_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               per_in = in_per;
               st_in = ST_OK;
               gs_in = SLOT_NONE;
               state_in = S_FIN;
               unique case (req_tuser)
                  FUNC_CLEAR: begin
                     count_in = '0;
                  end
                  FUNC_RESERVE: begin
                     if (full) begin
                        st_in = ST_FULL;
                     end else begin
                        wr_en = 1'b1;
                        wr_per = in_per;
                        wr_slot = in_slot;
                        count_in = count_ff + CntW'(1);
                        gs_in = in_slot;
                     end
                  end
                  FUNC_ALLOCATE: begin
                     if (full) begin
                        st_in = ST_FULL;
                     end else if (count_ff == '0) begin
                        wr_en = 1'b1;
                        wr_per = in_per;
                        wr_slot = SlotW'(1);
                        count_in = CntW'(1);
                        gs_in = SlotW'(1);
                     end else if (in_per <= SlotW'(1)) begin
                        st_in = ST_NOFREE;
                     end else begin
                        lane_ctl.clear = 1'b1;
                        idx_in = '0;
                        state_in = S_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_RD: begin
            state_in = S_CHK;
         end
         S_CHK: begin
            if (rd_slot_ff == SLOT_NONE) begin
               // unassigned entry never conflicts
               if (last_entry) begin
                  state_in = S_SINIT;
               end else begin
                  idx_in = idx_ff + IdxW'(1);
                  state_in = S_RD;
               end
            end else if (rd_per_ff == '0) begin
               st_in = ST_NOFREE;
               state_in = S_FIN;
            end else begin
               mod_start = 1'b1;
               if (per_ff > rd_per_ff) begin
                  mod_dividend = per_ff;
                  mod_divisor = rd_per_ff;
                  small_in = rd_per_ff;
               end else begin
                  mod_dividend = rd_per_ff;
                  mod_divisor = per_ff;
                  small_in = per_ff;
               end
               state_in = S_DIV1;
            end
         end
         S_DIV1: begin
            if (mod_done) begin
               if (mod_rem != '0) begin
                  st_in = ST_NOFREE;
                  state_in = S_FIN;
               end else begin
                  mod_start = 1'b1;
                  state_in = S_DIV2;
               end
            end
         end
         S_DIV2: begin
            if (mod_done) begin
               lane_ctl.load = 1'b1;
               if (last_entry) begin
                  state_in = S_SINIT;
               end else begin
                  idx_in = idx_ff + IdxW'(1);
                  state_in = S_RD;
               end
            end
         end
         S_SINIT: begin
            lane_ctl.init = 1'b1;
            cand_in = SlotW'(1);
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (cand_ff == per_ff) begin
               st_in = ST_NOFREE;
               state_in = S_FIN;
            end else if (cand_free) begin
               wr_en = 1'b1;
               count_in = count_ff + CntW'(1);
               gs_in = cand_ff;
               state_in = S_FIN;
            end else begin
               lane_ctl.step = 1'b1;
               cand_in = cand_ff + SlotW'(1);
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_st_in = st_ff;
               rsp_slot_in = gs_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_per[count_ff[IdxW-1:0]] <= wr_per;
         mem_slot[count_ff[IdxW-1:0]] <= wr_slot;
      end
      rd_per_ff <= mem_per[idx_ff];
      rd_slot_ff <= mem_slot[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff <= idx_in;
      per_ff <= per_in;
      cand_ff <= cand_in;
      small_ff <= small_in;
      st_ff <= st_in;
      gs_ff <= gs_in;
      rsp_st_ff <= rsp_st_in;
      rsp_slot_ff <= rsp_slot_in;
   end

   psa_serial_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (mod_dividend),
      .divisor   (mod_divisor),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   psa_scan_lanes #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_lanes (
      .clock     (clock),
      .reset     (reset),
      .ctl       (lane_ctl),
      .load_idx  (idx_ff),
      .load_mod  (small_ff),
      .load_res  (mod_rem),
      .cand_free (cand_free)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_slot_ff;
   assign rsp_tuser = rsp_st_ff;

endmodule

/* tb/tb.sv */
// Self-checking testbench for periodic_slot_allocator: random and directed table operations.
`timescale 1ns / 100ps

module tb;
   import psa_pkg::*;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int         ENTRIES     = TableEntriesDef;
   localparam int         WATCHDOG    = 300000;

   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] period;
      logic [15:0] slot;
   } op_item_t;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] granted;
   } grant_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   periodic_slot_allocator dut (.*);

   // predictor copy of the reservation table
   logic [15:0] tbl_period [ENTRIES];
   logic [15:0] tbl_slot   [ENTRIES];
   int          tbl_count = 0;

   op_item_t pending_ops[$];
   grant_t   expected_grants[$];
   int       sent_count = 0;
   int       grant_count = 0;
   int       total_ops = 0;
   int       mismatch_count = 0;
   int       n_ok = 0, n_nofree = 0, n_full = 0;
   int       idle_cycles = 0;
   int       send_idle_pct = 32, recv_idle_pct = 81;
   bit       drained_once = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic bit candidate_free(int cand, int per);
      int ep, es, sm;
      for (int i = 0; i < tbl_count; i++) begin
         ep = tbl_period[i];
         es = tbl_slot[i];
         if (es == SLOT_NONE) continue;
         if (ep == 0 || per == 0) return 0;
         if (per > ep) begin
            if (per % ep != 0) return 0;
            sm = ep;
         end else begin
            if (ep % per != 0) return 0;
            sm = per;
         end
         if (cand % sm == es % sm) return 0;
      end
      return 1;
   endfunction

   function automatic grant_t predict_grant(op_item_t op);
      grant_t g;
      g.status  = ST_OK;
      g.granted = SLOT_NONE;
      case (op.func)
         FUNC_CLEAR: tbl_count = 0;
         FUNC_RESERVE: begin
            if (tbl_count >= ENTRIES) g.status = ST_FULL;
            else begin
               tbl_period[tbl_count] = op.period;
               tbl_slot[tbl_count]   = op.slot;
               tbl_count++;
               g.granted = op.slot;
            end
         end
         FUNC_ALLOCATE: begin
            if (tbl_count >= ENTRIES) g.status = ST_FULL;
            else if (tbl_count == 0) begin
               tbl_period[0] = op.period;
               tbl_slot[0]   = 16'd1;
               tbl_count     = 1;
               g.granted     = 16'd1;
            end else begin
               g.status = ST_NOFREE;
               for (int c = 1; c < int'(op.period); c++) begin
                  if (candidate_free(c, op.period)) begin
                     tbl_period[tbl_count] = op.period;
                     tbl_slot[tbl_count]   = c[15:0];
                     tbl_count++;
                     g.granted = c[15:0];
                     g.status  = ST_OK;
                     break;
                  end
               end
            end
         end
         default: ;
      endcase
      return g;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("ERROR item %0d: %s got %0d expected %0d", grant_count, what, got, want);
      mismatch_count++;
   endtask

   task automatic push_op(logic [1:0] f, int per, int sl);
      op_item_t op;
      op.func   = f;
      op.period = per[15:0];
      op.slot   = sl[15:0];
      pending_ops.push_back(op);
   endtask

   // driver
   always @(posedge clock) begin
      op_item_t op;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            op.func   = req_tuser;
            op.period = req_tdata[15:0];
            op.slot   = req_tdata[31:16];
            expected_grants.push_back(predict_grant(op));
            sent_count++;
            if (sent_count == 200) begin
               send_idle_pct = 81;
               recv_idle_pct = 32;
            end else if (sent_count == 400) begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         end
         if (!req_tvalid || req_tready) begin
            if (sent_count >= 300 && !drained_once && expected_grants.size() != 0) begin
               req_tvalid <= 1'b0;
            end else if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               if (sent_count >= 300) drained_once = 1;
               op = pending_ops.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= op.func;
               req_tdata  <= {op.slot, op.period};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor and receiver stalls
   always @(posedge clock) begin
      grant_t want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            grant_count++;
            if (expected_grants.size() == 0) begin
               report_mismatch("unexpected item, status", rsp_tuser, -1);
            end else begin
               want = expected_grants.pop_front();
               if (rsp_tuser !== want.status)
                  report_mismatch("status", rsp_tuser, want.status);
               if (rsp_tdata !== want.granted)
                  report_mismatch("granted_slot", rsp_tdata, want.granted);
               case (want.status)
                  ST_OK:     n_ok++;
                  ST_NOFREE: n_nofree++;
                  default:   n_full++;
               endcase
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
         $display("Timeout with %0d results outstanding", expected_grants.size());
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic int harmonic_period();
      int base[11] = '{2, 4, 8, 16, 32, 64, 3, 6, 12, 24, 48};
      return base[$urandom_range(10)];
   endfunction

   initial begin
      int per, r;
      // directed
      push_op(FUNC_ALLOCATE, 65535, 0);        // empty table grants slot 1
      push_op(FUNC_RESERVE, 0, 65535);         // unassigned entry, never conflicts
      push_op(FUNC_ALLOCATE, 4, 0);
      push_op(FUNC_ALLOCATE, 1, 0);            // no candidates
      push_op(FUNC_ALLOCATE, 0, 0);
      push_op(FUNC_UNUSED, 16'hFFFF, 16'hFFFF);
      push_op(FUNC_CLEAR, 16'hFFFF, 16'hFFFF);
      push_op(FUNC_RESERVE, 8, 0);
      push_op(FUNC_ALLOCATE, 8, 0);
      push_op(FUNC_ALLOCATE, 16, 0);
      push_op(FUNC_RESERVE, 0, 5);             // zero period blocks all candidates
      push_op(FUNC_ALLOCATE, 8, 0);
      push_op(FUNC_ALLOCATE, 65535, 0);        // not a multiple of the first entry's period, no free slot
      push_op(FUNC_CLEAR, 0, 0);
      for (int i = 0; i < 16; i++) push_op(FUNC_RESERVE, 16'hFFFF, 16'hAAAA ^ i);
      push_op(FUNC_RESERVE, 4, 1);             // table full
      push_op(FUNC_ALLOCATE, 4, 0);
      push_op(FUNC_CLEAR, 0, 0);
      // random: mostly well-formed harmonic allocation runs
      while (pending_ops.size() < 580) begin
         push_op(FUNC_CLEAR, $urandom, $urandom);
         repeat ($urandom_range(20, 4)) begin
            r = $urandom_range(99);
            per = harmonic_period();
            if (r < 70) push_op(FUNC_ALLOCATE, per, $urandom);
            else if (r < 80) push_op(FUNC_RESERVE, per, $urandom_range(per - 1));
            else if (r < 85) push_op(FUNC_ALLOCATE, $urandom_range(4096, 1024), $urandom);
            else if (r < 92) push_op(FUNC_RESERVE, $urandom, $urandom);
            else if (r < 96) push_op(FUNC_UNUSED, $urandom, $urandom);
            else push_op(FUNC_ALLOCATE, $urandom_range(96), $urandom);
         end
      end
      total_ops = pending_ops.size();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      wait (grant_count >= total_ops);
      repeat (100) @(posedge clock);
      $display("Ran %0d table operations: %0d granted, %0d without free slot, %0d table full",
               sent_count, n_ok, n_nofree, n_full);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
